### src/gtg_pkg.sv
// types, constants and the arctangent table shared by the go-to-goal steering blocks
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package gtg_pkg;

   // datapath sizing
   localparam int CORDIC_STEPS  = 16;
   localparam int COORD_BITS    = 16;
   localparam int PRESHIFT      = 40 - COORD_BITS;
   localparam int DIFF_BITS     = COORD_BITS + 1;
   localparam int CX_BITS       = 44;
   localparam int Z_BITS        = 32;
   localparam int STEP_BITS     = $clog2(CORDIC_STEPS);
   localparam int ATAN_IDX_BITS = 5;
   localparam int SPLIT_BITS    = 16;
   localparam int HEADING_BITS  = 15;
   localparam int ANG_BITS      = 16;
   localparam int ERR_BITS      = 17;
   localparam int LIN_BITS      = 15;
   localparam int ANGV_BITS     = 15;
   localparam int DIST_BITS     = (COORD_BITS + 1 > LIN_BITS + 1) ? COORD_BITS + 1 : LIN_BITS + 1;
   localparam int GAIN_BITS     = 8;
   localparam int DTOL_BITS     = 16;
   localparam int ATOL_BITS     = 14;
   localparam int CMD_BITS      = 2;
   localparam int CSR_ADDR_BITS = 2;
   localparam int CSR_DATA_BITS = 16;
   localparam int QDEPTH        = 4;
   localparam int QA_BITS       = $clog2(QDEPTH);

   localparam int REQ_DATA_BITS = ((2 * COORD_BITS + HEADING_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((LIN_BITS + ANGV_BITS + 1 + 7) / 8) * 8;

   // fixed-point constants
   localparam int PI_Q12      = 12868;
   localparam int TWO_PI_Q12  = 25736;
   localparam int HALF_PI_Q28 = 421657428;
   localparam int ROUND_Q16   = 32768;
   localparam logic [SPLIT_BITS-1:0] INV_GAIN_Q16 = 16'd39797;

   // reset values
   localparam logic [COORD_BITS-1:0] TARGET_RESET    = COORD_BITS'(1280);
   localparam logic [GAIN_BITS-1:0]  GAIN_LIN_RESET  = 8'd128;
   localparam logic [GAIN_BITS-1:0]  GAIN_ANG_RESET  = 8'd128;
   localparam logic [DTOL_BITS-1:0]  DTOL_RESET      = 16'd26;
   localparam logic [ATOL_BITS-1:0]  ATOL_RESET      = 14'd410;

   // command codes
   localparam logic [CMD_BITS-1:0] CMD_POSE = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_GOAL = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_TICK = 2'd2;
   localparam logic [CMD_BITS-1:0] CMD_NONE = 2'd3;

   // register indexes
   localparam logic [CSR_ADDR_BITS-1:0] CSR_GAIN_LIN = 2'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_GAIN_ANG = 2'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_DIST_TOL = 2'd2;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_ANG_TOL  = 2'd3;

   typedef struct packed {
      logic [CMD_BITS-1:0]            kind;
      logic signed [COORD_BITS-1:0]   pos_x;
      logic signed [COORD_BITS-1:0]   pos_y;
      logic signed [HEADING_BITS-1:0] heading;
   } job_type;

   typedef struct packed {
      logic signed [CX_BITS-1:0] x;
      logic signed [Z_BITS-1:0]  z;
   } cordic_res_type;

   // atan(2^-i) in Q3.28
   function automatic logic signed [Z_BITS-1:0] atan_q28(input logic [ATAN_IDX_BITS-1:0] idx);
      logic signed [Z_BITS-1:0] v;
      case (idx)
         5'd0:  v = 32'sd210828714;
         5'd1:  v = 32'sd124459457;
         5'd2:  v = 32'sd65760959;
         5'd3:  v = 32'sd33381290;
         5'd4:  v = 32'sd16755422;
         5'd5:  v = 32'sd8385879;
         5'd6:  v = 32'sd4193963;
         5'd7:  v = 32'sd2097109;
         5'd8:  v = 32'sd1048571;
         5'd9:  v = 32'sd524287;
         5'd10: v = 32'sd262144;
         5'd11: v = 32'sd131072;
         5'd12: v = 32'sd65536;
         5'd13: v = 32'sd32768;
         5'd14: v = 32'sd16384;
         5'd15: v = 32'sd8192;
         5'd16: v = 32'sd4096;
         5'd17: v = 32'sd2048;
         5'd18: v = 32'sd1024;
         5'd19: v = 32'sd512;
         5'd20: v = 32'sd256;
         5'd21: v = 32'sd128;
         5'd22: v = 32'sd64;
         5'd23: v = 32'sd32;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

### src/gtg_front.sv
// request side: accepts items, drops unused commands, queues jobs for the back end
// depends on gtg_pkg
`timescale 1ns / 1ps
`default_nettype none

module gtg_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [gtg_pkg::CMD_BITS-1:0]        req_tuser,
   input  logic [gtg_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   output logic                                q_valid,
   input  logic                                q_pop,
   output gtg_pkg::job_type                    q_job
);
   import gtg_pkg::*;

   job_type              mem_ff [QDEPTH];
   logic [QA_BITS-1:0]   wr_ptr_ff;
   logic [QA_BITS-1:0]   rd_ptr_ff;
   logic [QA_BITS:0]     count_ff;
   logic [QA_BITS:0]     count_in;
   logic                 push;
   job_type              job_in;

   assign req_tready = (count_ff != (QA_BITS + 1)'(QDEPTH));
   assign push       = req_tvalid && req_tready && (req_tuser != CMD_NONE);
   assign q_valid    = (count_ff != '0);
   assign q_job      = mem_ff[rd_ptr_ff];

   always_comb begin
      job_in.kind    = req_tuser;
      job_in.pos_x   = req_tdata[COORD_BITS-1:0];
      job_in.pos_y   = req_tdata[2*COORD_BITS-1:COORD_BITS];
      job_in.heading = req_tdata[2*COORD_BITS+HEADING_BITS-1:2*COORD_BITS];
   end

   always_comb begin
      case ({push, q_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (q_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= job_in;
      end
   end

endmodule

`default_nettype wire

### src/gtg_cordic.sv
// iterative vectoring cordic: one micro-rotation per cycle, quadrant pre-rotation on start
// depends on gtg_pkg
`timescale 1ns / 1ps
`default_nettype none

module gtg_cordic (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic signed [gtg_pkg::DIFF_BITS-1:0]  dx,
   input  logic signed [gtg_pkg::DIFF_BITS-1:0]  dy,
   output logic                                  done,
   output gtg_pkg::cordic_res_type               res
);
   import gtg_pkg::*;

   localparam int EXT_BITS = CX_BITS - DIFF_BITS - PRESHIFT;
   localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(CORDIC_STEPS - 1);
   localparam logic signed [Z_BITS-1:0] HALF_PI = Z_BITS'(HALF_PI_Q28);

   logic                      busy_ff;
   logic                      done_ff;
   logic [STEP_BITS-1:0]      step_ff;
   logic signed [CX_BITS-1:0] x_ff;
   logic signed [CX_BITS-1:0] y_ff;
   logic signed [Z_BITS-1:0]  z_ff;

   logic signed [CX_BITS-1:0] x0;
   logic signed [CX_BITS-1:0] y0;
   logic signed [CX_BITS-1:0] xr;
   logic signed [CX_BITS-1:0] yr;
   logic signed [Z_BITS-1:0]  zr;
   logic signed [CX_BITS-1:0] xs;
   logic signed [CX_BITS-1:0] ys;
   logic signed [Z_BITS-1:0]  at;

   assign x0 = {{EXT_BITS{dx[DIFF_BITS-1]}}, dx, {PRESHIFT{1'b0}}};
   assign y0 = {{EXT_BITS{dy[DIFF_BITS-1]}}, dy, {PRESHIFT{1'b0}}};

   // fold the left half-plane onto the right one
   always_comb begin
      if (x0 < 0) begin
         if (y0 >= 0) begin
            xr = y0;
            yr = -x0;
            zr = HALF_PI;
         end else begin
            xr = -y0;
            yr = x0;
            zr = -HALF_PI;
         end
      end else begin
         xr = x0;
         yr = y0;
         zr = '0;
      end
   end

   assign xs = x_ff >>> step_ff;
   assign ys = y_ff >>> step_ff;
   assign at = atan_q28(ATAN_IDX_BITS'(step_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= !start && busy_ff && (step_ff == STEP_LAST);
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == STEP_LAST) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff <= xr;
         y_ff <= yr;
         z_ff <= zr;
      end else if (busy_ff) begin
         if (y_ff > 0) begin
            x_ff <= x_ff + ys;
            y_ff <= y_ff - xs;
            z_ff <= z_ff + at;
         end else begin
            x_ff <= x_ff - ys;
            y_ff <= y_ff + xs;
            z_ff <= z_ff - at;
         end
      end
   end

   assign done  = done_ff;
   assign res.x = x_ff;
   assign res.z = z_ff;

endmodule

`default_nettype wire

### src/gtg_back.sv
// execution side: pose and goal state, config registers, tick sequencer and result register
// depends on gtg_pkg; drives gtg_cordic through start/done
`timescale 1ns / 1ps
`default_nettype none

module gtg_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [gtg_pkg::CSR_ADDR_BITS-1:0]     csr_addr,
   input  logic [gtg_pkg::CSR_DATA_BITS-1:0]     csr_wdata,
   input  logic                                  q_valid,
   output logic                                  q_pop,
   input  gtg_pkg::job_type                      q_job,
   output logic                                  cordic_start,
   output logic signed [gtg_pkg::DIFF_BITS-1:0]  cordic_dx,
   output logic signed [gtg_pkg::DIFF_BITS-1:0]  cordic_dy,
   input  logic                                  cordic_done,
   input  gtg_pkg::cordic_res_type               cordic_res,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [gtg_pkg::LIN_BITS-1:0]          rsp_lin,
   output logic [gtg_pkg::ANGV_BITS-1:0]         rsp_ang,
   output logic                                  rsp_reached
);
   import gtg_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_WAIT  = 3'd1;
   localparam logic [2:0] ST_MUL0  = 3'd2;
   localparam logic [2:0] ST_MUL1  = 3'd3;
   localparam logic [2:0] ST_WRAP  = 3'd4;
   localparam logic [2:0] ST_SCALE = 3'd5;
   localparam logic [2:0] ST_OUT   = 3'd6;

   localparam int HI_BITS  = CX_BITS - SPLIT_BITS;
   localparam int SUM_BITS = CX_BITS + 1;
   localparam int LP_BITS  = DIST_BITS + GAIN_BITS;
   localparam int AP_BITS  = ERR_BITS + GAIN_BITS + 1;
   localparam logic signed [ERR_BITS-1:0] PI_E     = ERR_BITS'(PI_Q12);
   localparam logic signed [ERR_BITS-1:0] TWO_PI_E = ERR_BITS'(TWO_PI_Q12);

   logic [2:0]                       state_ff;
   logic [2:0]                       state_in;
   logic [GAIN_BITS-1:0]             gain_lin_ff;
   logic [GAIN_BITS-1:0]             gain_ang_ff;
   logic [DTOL_BITS-1:0]             dtol_ff;
   logic [ATOL_BITS-1:0]             atol_ff;
   logic signed [COORD_BITS-1:0]     robot_x_ff;
   logic signed [COORD_BITS-1:0]     robot_y_ff;
   logic signed [HEADING_BITS-1:0]   robot_hd_ff;
   logic signed [COORD_BITS-1:0]     target_x_ff;
   logic signed [COORD_BITS-1:0]     target_y_ff;
   logic                             driving_ff;
   logic [2*SPLIT_BITS-1:0]          p0_ff;
   logic signed [ANG_BITS-1:0]       ang_ff;
   logic [DIST_BITS-1:0]             dist_ff;
   logic signed [ERR_BITS-1:0]       err_ff;
   logic                             far_ff;
   logic [LIN_BITS-1:0]              res_lin_ff;
   logic [ANGV_BITS-1:0]             res_ang_ff;
   logic                             res_reached_ff;
   logic                             rsp_valid_ff;
   logic [LIN_BITS-1:0]              rsp_lin_ff;
   logic [ANGV_BITS-1:0]             rsp_ang_ff;
   logic                             rsp_reached_ff;

   logic                             out_free;
   logic                             is_tick;
   logic [SPLIT_BITS-1:0]            x_lo;
   logic [HI_BITS-1:0]               x_hi;
   logic [2*SPLIT_BITS-1:0]          p0_in;
   logic signed [Z_BITS-1:0]         z_round;
   logic [CX_BITS-1:0]               hi_prod;
   logic [SUM_BITS-1:0]              dist_sum;
   logic signed [ERR_BITS-1:0]       err_in;
   logic signed [ERR_BITS-1:0]       err_wrap;
   logic [ERR_BITS-1:0]              err_abs;
   logic [LP_BITS-1:0]               lin_prod;
   logic signed [AP_BITS-1:0]        ang_prod;
   logic [LIN_BITS-1:0]              lin_sat;

   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign q_pop        = (state_ff == ST_IDLE) && q_valid;
   assign is_tick      = (q_job.kind == CMD_TICK);
   assign cordic_start = q_pop && is_tick && driving_ff;
   assign cordic_dx    = {target_x_ff[COORD_BITS-1], target_x_ff}
                         - {robot_x_ff[COORD_BITS-1], robot_x_ff};
   assign cordic_dy    = {target_y_ff[COORD_BITS-1], target_y_ff}
                         - {robot_y_ff[COORD_BITS-1], robot_y_ff};

   // magnitude times 1/K, split in two partial products
   assign x_lo     = cordic_res.x[SPLIT_BITS-1:0];
   assign x_hi     = cordic_res.x[CX_BITS-1:SPLIT_BITS];
   assign p0_in    = (2*SPLIT_BITS)'(x_lo) * (2*SPLIT_BITS)'(INV_GAIN_Q16);
   assign hi_prod  = CX_BITS'(x_hi) * CX_BITS'(INV_GAIN_Q16);
   assign dist_sum = SUM_BITS'(hi_prod) + SUM_BITS'(p0_ff[2*SPLIT_BITS-1:SPLIT_BITS]);
   assign z_round  = cordic_res.z + Z_BITS'(ROUND_Q16);
   assign err_in   = {ang_ff[ANG_BITS-1], ang_ff}
                     - {{(ERR_BITS-HEADING_BITS){robot_hd_ff[HEADING_BITS-1]}}, robot_hd_ff};

   always_comb begin
      if (err_ff > PI_E) begin
         err_wrap = err_ff - TWO_PI_E;
      end else if (err_ff < -PI_E) begin
         err_wrap = err_ff + TWO_PI_E;
      end else begin
         err_wrap = err_ff;
      end
   end

   assign err_abs  = err_ff[ERR_BITS-1] ? -err_ff : err_ff;
   assign lin_prod = LP_BITS'(gain_lin_ff) * LP_BITS'(dist_ff);
   assign ang_prod = $signed({1'b0, gain_ang_ff}) * err_ff;
   assign lin_sat  = (|lin_prod[LP_BITS-1:GAIN_BITS+LIN_BITS]) ? {LIN_BITS{1'b1}}
                                                             : lin_prod[GAIN_BITS +: LIN_BITS];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid && is_tick) begin
               state_in = driving_ff ? ST_WAIT : ST_OUT;
            end
         end
         ST_WAIT: begin
            if (cordic_done) begin
               state_in = ST_MUL0;
            end
         end
         ST_MUL0:  state_in = ST_MUL1;
         ST_MUL1:  state_in = ST_WRAP;
         ST_WRAP:  state_in = ST_SCALE;
         ST_SCALE: state_in = ST_OUT;
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         gain_lin_ff  <= GAIN_LIN_RESET;
         gain_ang_ff  <= GAIN_ANG_RESET;
         dtol_ff      <= DTOL_RESET;
         atol_ff      <= ATOL_RESET;
         robot_x_ff   <= '0;
         robot_y_ff   <= '0;
         robot_hd_ff  <= '0;
         target_x_ff  <= TARGET_RESET;
         target_y_ff  <= TARGET_RESET;
         driving_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            unique case (csr_addr)
               CSR_GAIN_LIN: gain_lin_ff <= csr_wdata[GAIN_BITS-1:0];
               CSR_GAIN_ANG: gain_ang_ff <= csr_wdata[GAIN_BITS-1:0];
               CSR_DIST_TOL: dtol_ff     <= csr_wdata[DTOL_BITS-1:0];
               CSR_ANG_TOL:  atol_ff     <= csr_wdata[ATOL_BITS-1:0];
               default: ;
            endcase
         end
         if (q_pop) begin
            unique case (q_job.kind)
               CMD_POSE: begin
                  robot_x_ff  <= q_job.pos_x;
                  robot_y_ff  <= q_job.pos_y;
                  robot_hd_ff <= q_job.heading;
               end
               CMD_GOAL: begin
                  target_x_ff <= q_job.pos_x;
                  target_y_ff <= q_job.pos_y;
                  driving_ff  <= 1'b1;
               end
               default: ;
            endcase
         end
         if (state_ff == ST_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
            if (res_reached_ff) begin
               driving_ff <= 1'b0;
            end
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop && is_tick && !driving_ff) begin
         res_lin_ff     <= '0;
         res_ang_ff     <= '0;
         res_reached_ff <= 1'b0;
      end
      if (state_ff == ST_MUL0) begin
         p0_ff  <= p0_in;
         ang_ff <= z_round[Z_BITS-1 -: ANG_BITS];
      end
      if (state_ff == ST_MUL1) begin
         dist_ff <= dist_sum[PRESHIFT +: DIST_BITS];
         err_ff  <= err_in;
      end
      if (state_ff == ST_WRAP) begin
         err_ff <= err_wrap;
         far_ff <= (dist_ff > DIST_BITS'(dtol_ff));
      end
      if (state_ff == ST_SCALE) begin
         res_reached_ff <= !far_ff;
         if (far_ff && (err_abs > ERR_BITS'(atol_ff))) begin
            res_lin_ff <= '0;
            res_ang_ff <= ang_prod[GAIN_BITS +: ANGV_BITS];
         end else if (far_ff) begin
            res_lin_ff <= lin_sat;
            res_ang_ff <= '0;
         end else begin
            res_lin_ff <= '0;
            res_ang_ff <= '0;
         end
      end
      if (state_ff == ST_OUT && out_free) begin
         rsp_lin_ff     <= res_lin_ff;
         rsp_ang_ff     <= res_ang_ff;
         rsp_reached_ff <= res_reached_ff;
      end
   end

   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_lin     = rsp_lin_ff;
   assign rsp_ang     = rsp_ang_ff;
   assign rsp_reached = rsp_reached_ff;

   a_reached_still : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_reached_ff) |-> (rsp_lin_ff == '0 && rsp_ang_ff == '0))
      else $error("reached item carries a nonzero velocity");

   a_one_motion : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_lin_ff == '0 || rsp_ang_ff == '0))
      else $error("item drives and turns at once");

   a_disarm : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && out_free && res_reached_ff) |=> !driving_ff)
      else $error("driving flag still set after goal reached");

   a_done_in_wait : assert property (@(posedge clock) disable iff (reset)
      cordic_done |-> state_ff == ST_WAIT)
      else $error("cordic finished outside the wait state");

endmodule

`default_nettype wire

### src/go_to_goal_steering_controller_top.sv
// go-to-goal steering controller top level: front queue, cordic unit and back end
// depends on gtg_pkg, gtg_front, gtg_cordic, gtg_back
//
// channel  dir  handshake              contents
// req      in   req_tvalid/req_tready  tuser: cmd; tdata: pos_x, pos_y, heading
// rsp      out  rsp_tvalid/rsp_tready  tdata: linear_velocity, angular_velocity, goal_reached
// csr      in   csr_we                 csr_addr: register index, csr_wdata: value
//
// pose and goal items are applied as they are popped, the back end staying idle; an idle tick
// passes through the output state, and a driving tick waits for the cordic loop at one
// micro-rotation per cycle, then passes through the multiply, wrap, scale and output states
// a four-entry queue keeps accepting items until full while the back end works or the result stalls
// synchronous reset restores pose, goal, flag and registers at once; no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module go_to_goal_steering_controller_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [gtg_pkg::CMD_BITS-1:0]        req_tuser,  // cmd
   input  logic [gtg_pkg::REQ_DATA_BITS-1:0]   req_tdata,  // pos_x, pos_y, heading, zero pad
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [gtg_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,  // linear_velocity, angular_velocity,
                                                           // goal_reached, zero pad
   input  logic                                csr_we,
   input  logic [gtg_pkg::CSR_ADDR_BITS-1:0]   csr_addr,
   input  logic [gtg_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import gtg_pkg::*;

   localparam int PAD_BITS = RSP_DATA_BITS - LIN_BITS - ANGV_BITS - 1;

   logic                        q_valid;
   logic                        q_pop;
   job_type                     q_job;
   logic                        cordic_start;
   logic signed [DIFF_BITS-1:0] cordic_dx;
   logic signed [DIFF_BITS-1:0] cordic_dy;
   logic                        cordic_done;
   cordic_res_type              cordic_res;
   logic [LIN_BITS-1:0]         rsp_lin;
   logic [ANGV_BITS-1:0]        rsp_ang;
   logic                        rsp_reached;

   gtg_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .q_valid    (q_valid),
      .q_pop      (q_pop),
      .q_job      (q_job)
   );

   gtg_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cordic_start),
      .dx    (cordic_dx),
      .dy    (cordic_dy),
      .done  (cordic_done),
      .res   (cordic_res)
   );

   gtg_back u_back (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_addr     (csr_addr),
      .csr_wdata    (csr_wdata),
      .q_valid      (q_valid),
      .q_pop        (q_pop),
      .q_job        (q_job),
      .cordic_start (cordic_start),
      .cordic_dx    (cordic_dx),
      .cordic_dy    (cordic_dy),
      .cordic_done  (cordic_done),
      .cordic_res   (cordic_res),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_lin      (rsp_lin),
      .rsp_ang      (rsp_ang),
      .rsp_reached  (rsp_reached)
   );

   assign rsp_tdata = {{PAD_BITS{1'b0}}, rsp_reached, rsp_ang, rsp_lin};

endmodule

`default_nettype wire

### bench/go_to_goal_steering_controller_top_tb.sv
// self-checking bench for go_to_goal_steering_controller_top: queue-fed driver, clocked monitor
// and a bit-accurate cordic steering predictor; depends on gtg_pkg and the top level
`timescale 1ns / 1ps

module go_to_goal_steering_controller_top_tb;
   import gtg_pkg::*;

   localparam int STALL_LIMIT = 5000;
   localparam int SETTLE_CYCLES = 64;
   localparam int ITEMS_PER_PHASE = 190;

   typedef struct packed {
      logic [LIN_BITS-1:0]  lin;
      logic [ANGV_BITS-1:0] angv;
      logic                 reached;
   } vel_cmd_type;

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [CMD_BITS-1:0]      req_tuser;   // cmd
   logic [REQ_DATA_BITS-1:0] req_tdata;   // pos_x, pos_y, heading, zero pad
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;   // linear_velocity, angular_velocity, goal_reached, pad
   logic                     csr_we;
   logic [CSR_ADDR_BITS-1:0] csr_addr;
   logic [CSR_DATA_BITS-1:0] csr_wdata;

   job_type     pending_jobs[$];
   vel_cmd_type expected_cmds[$];
   logic        req_fire;
   int          send_idle_pct;
   int          recv_idle_pct;
   int          errors;
   int          jobs_queued;
   int          stall_count;
   int          gen_dtol;
   int          gen_atol;

   // predictor state
   longint rob_x, rob_y, rob_h, tgt_x, tgt_y;
   longint gain_lin, gain_ang, dist_tol, ang_tol;
   logic   driving;

   go_to_goal_steering_controller_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   function automatic longint atan_step(int i);
      case (i)
         0:  return 210828714;
         1:  return 124459457;
         2:  return 65760959;
         3:  return 33381290;
         4:  return 16755422;
         5:  return 8385879;
         6:  return 4193963;
         7:  return 2097109;
         8:  return 1048571;
         9:  return 524287;
         10: return 262144;
         11: return 131072;
         12: return 65536;
         13: return 32768;
         14: return 16384;
         15: return 8192;
         default: return 0;
      endcase
   endfunction

   // vectoring pass: bearing in Q3.12 and range in unsigned Q9.8
   function automatic void to_polar(input longint dx, input longint dy,
                                    output longint ang, output longint dist_q8);
      longint x, y, z, t, xs, ys;
      z = 0;
      if (dx == 0 && dy == 0) begin
         ang = 0;
         dist_q8 = 0;
         return;
      end
      x = dx * (longint'(1) << PRESHIFT);
      y = dy * (longint'(1) << PRESHIFT);
      if (x < 0) begin
         if (y >= 0) begin
            t = y; y = -x; x = t; z = HALF_PI_Q28;
         end else begin
            t = -y; y = x; x = t; z = -HALF_PI_Q28;
         end
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x = x + ys; y = y - xs; z = z + atan_step(i);
         end else begin
            x = x - ys; y = y + xs; z = z - atan_step(i);
         end
      end
      ang = (z + 32768) >>> 16;
      dist_q8 = (x * longint'(39797)) >>> (16 + PRESHIFT);
   endfunction

   function automatic int rnd(int lo, int hi);
      return lo + int'($urandom_range(hi - lo));
   endfunction

   function automatic int clip(int v, int lo, int hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // predictor, checker and watchdog share the rising edge
   always @(posedge clock) begin : track
      vel_cmd_type want, got;
      longint ang, dist_q8, err, lin, angv;
      if (reset) begin
         rob_x = 0; rob_y = 0; rob_h = 0;
         tgt_x = 1280; tgt_y = 1280;
         driving = 1'b0;
         gain_lin = 128; gain_ang = 128; dist_tol = 26; ang_tol = 410;
         expected_cmds.delete();
         req_fire <= 1'b0;
         stall_count = 0;
      end else begin
         req_fire <= req_tvalid && req_tready;
         if (csr_we) begin
            case (csr_addr)
               CSR_GAIN_LIN: gain_lin = longint'(csr_wdata[GAIN_BITS-1:0]);
               CSR_GAIN_ANG: gain_ang = longint'(csr_wdata[GAIN_BITS-1:0]);
               CSR_DIST_TOL: dist_tol = longint'(csr_wdata[DTOL_BITS-1:0]);
               CSR_ANG_TOL:  ang_tol  = longint'(csr_wdata[ATOL_BITS-1:0]);
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            case (req_tuser)
               CMD_POSE: begin
                  rob_x = longint'($signed(req_tdata[15:0]));
                  rob_y = longint'($signed(req_tdata[31:16]));
                  rob_h = longint'($signed(req_tdata[46:32]));
               end
               CMD_GOAL: begin
                  tgt_x = longint'($signed(req_tdata[15:0]));
                  tgt_y = longint'($signed(req_tdata[31:16]));
                  driving = 1'b1;
               end
               CMD_TICK: begin
                  lin = 0;
                  angv = 0;
                  want.reached = 1'b0;
                  if (driving) begin
                     to_polar(tgt_x - rob_x, tgt_y - rob_y, ang, dist_q8);
                     if (dist_q8 > dist_tol) begin
                        err = ang - rob_h;
                        if (err > PI_Q12) err = err - TWO_PI_Q12;
                        if (err < -PI_Q12) err = err + TWO_PI_Q12;
                        if (((err < 0) ? -err : err) > ang_tol) begin
                           angv = (gain_ang * err) >>> 8;
                        end else begin
                           lin = (gain_lin * dist_q8) >>> 8;
                           if (lin > 32767) lin = 32767;
                        end
                     end else begin
                        want.reached = 1'b1;
                        driving = 1'b0;
                     end
                  end
                  want.lin = lin[LIN_BITS-1:0];
                  want.angv = angv[ANGV_BITS-1:0];
                  expected_cmds.push_back(want);
               end
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got.lin = rsp_tdata[14:0];
            got.angv = rsp_tdata[29:15];
            got.reached = rsp_tdata[30];
            if (expected_cmds.size() == 0) begin
               $display("%0t: unexpected item lin=%0d ang=%0d reached=%0b", $time,
                        got.lin, $signed(got.angv), got.reached);
               errors++;
            end else begin
               want = expected_cmds.pop_front();
               if (got.lin !== want.lin) begin
                  $display("%0t: linear_velocity expected %0d actual %0d", $time,
                           want.lin, got.lin);
                  errors++;
               end
               if (got.angv !== want.angv) begin
                  $display("%0t: angular_velocity expected %0d actual %0d", $time,
                           $signed(want.angv), $signed(got.angv));
                  errors++;
               end
               if (got.reached !== want.reached) begin
                  $display("%0t: goal_reached expected %0b actual %0b", $time,
                           want.reached, got.reached);
                  errors++;
               end
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
            stall_count = 0;
         else
            stall_count++;
         if (stall_count >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // driver
   always @(negedge clock) begin : drive
      job_type j;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (pending_jobs.size() != 0 && rnd(0, 99) >= send_idle_pct) begin
            j = pending_jobs.pop_front();
            req_tvalid <= 1'b1;
            req_tuser <= j.kind;
            req_tdata <= {1'b0, j.heading, j.pos_y, j.pos_x};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      rsp_tready <= (rnd(0, 99) >= recv_idle_pct);
   end

   task automatic push_job(logic [CMD_BITS-1:0] kind, int x, int y, int h);
      job_type j;
      j.kind = kind;
      j.pos_x = x[15:0];
      j.pos_y = y[15:0];
      j.heading = h[14:0];
      pending_jobs.push_back(j);
      if (kind != CMD_NONE) jobs_queued++;
   endtask

   task automatic push_noise();
      push_job(CMD_BITS'(rnd(0, 3)), rnd(-32768, 32767), rnd(-32768, 32767),
               rnd(-16384, 16383));
   endtask

   // goal, then poses closing in with ticks between, then arrival
   task automatic push_approach();
      int tx, ty, rx, ry, span, steps, h, r;
      longint ang, dist_q8;
      span = (rnd(0, 9) == 0) ? 32767 : 2048;
      tx = rnd(-span, span - 1);
      ty = rnd(-span, span - 1);
      rx = rnd(-span, span - 1);
      ry = rnd(-span, span - 1);
      push_job(CMD_GOAL, tx, ty, rnd(-16384, 16383));
      steps = rnd(1, 5);
      for (int i = 0; i < steps; i++) begin
         to_polar(tx - rx, ty - ry, ang, dist_q8);
         case (rnd(0, 2))
            0: h = int'(ang) + rnd(-gen_atol, gen_atol);
            1: h = rnd(-16384, 16383);
            default: h = int'(ang) + (rnd(0, 1) ? 1 : -1) * (gen_atol + rnd(-1, 1));
         endcase
         push_job(CMD_POSE, rx, ry, clip(h, -16384, 16383));
         push_job(CMD_TICK, rnd(-32768, 32767), rnd(-32768, 32767), rnd(-16384, 16383));
         if (rnd(0, 3) == 0) push_job(CMD_TICK, 0, 0, 0);
         rx = rx + (tx - rx) / 2;
         ry = ry + (ty - ry) / 2;
      end
      r = gen_dtol / 2;
      push_job(CMD_POSE, clip(tx + rnd(-r, r), -32768, 32767),
               clip(ty + rnd(-r, r), -32768, 32767), rnd(-16384, 16383));
      push_job(CMD_TICK, rnd(-32768, 32767), rnd(-32768, 32767), rnd(-16384, 16383));
      if (rnd(0, 1)) push_job(CMD_TICK, 0, 0, 0);
   endtask

   task automatic drain();
      while (pending_jobs.size() != 0 || req_tvalid || expected_cmds.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_regs(int gl, int ga, int dt, int at);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= CSR_GAIN_LIN;
      csr_wdata <= CSR_DATA_BITS'(gl);
      @(negedge clock);
      csr_addr <= CSR_GAIN_ANG;
      csr_wdata <= CSR_DATA_BITS'(ga);
      @(negedge clock);
      csr_addr <= CSR_DIST_TOL;
      csr_wdata <= CSR_DATA_BITS'(dt);
      @(negedge clock);
      csr_addr <= CSR_ANG_TOL;
      csr_wdata <= CSR_DATA_BITS'(at);
      @(negedge clock);
      csr_we <= 1'b0;
      gen_dtol = dt;
      gen_atol = at;
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = '0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_addr = '0;
      csr_wdata = '0;
      errors = 0;
      jobs_queued = 0;
      send_idle_pct = 30;
      recv_idle_pct = 64;
      gen_dtol = 26;
      gen_atol = 410;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part under reset register values
      push_job(CMD_TICK, 0, 0, 0);                 // idle tick
      push_job(CMD_NONE, 12345, -321, 777);        // unused command
      push_job(CMD_GOAL, 1280, 0, 12345);          // heading ignored on goal
      push_job(CMD_TICK, 0, 0, 0);                 // drive straight
      push_job(CMD_POSE, 0, 0, 12868);
      push_job(CMD_TICK, 0, 0, 0);                 // turn in place
      push_job(CMD_POSE, 0, 0, -16384);            // heading beyond pi
      push_job(CMD_TICK, 0, 0, 0);
      push_job(CMD_POSE, -32768, -32768, 16383);
      push_job(CMD_GOAL, 32767, 32767, -16384);
      push_job(CMD_TICK, -1, -1, -1);
      push_job(CMD_POSE, -32768, -32768, 3217);
      push_job(CMD_TICK, 0, 0, 0);                 // saturated linear speed
      push_job(CMD_POSE, 32767, 32767, 0);
      push_job(CMD_TICK, 0, 0, 0);                 // zero offset, reached
      push_job(CMD_TICK, 0, 0, 0);                 // idle after reached
      push_job(CMD_GOAL, -32768, 32767, 0);
      push_job(CMD_TICK, 0, 0, 0);
      push_job(CMD_POSE, 32767, 0, -12868);
      push_job(CMD_GOAL, -32768, -32768, 0);
      push_job(CMD_TICK, 0, 0, 0);
      push_job(CMD_POSE, 0, 100, 0);
      push_job(CMD_GOAL, 0, 0, 0);
      push_job(CMD_TICK, 0, 0, 0);
      push_job(CMD_TICK, 0, 0, 0);
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: write_regs(0, 0, 0, 0);
            1: write_regs(255, 255, 65535, 12868);
            2: write_regs(128, 128, 26, 410);
            default: write_regs(rnd(0, 255), rnd(0, 255), rnd(0, 600), rnd(0, 12868));
         endcase
         send_idle_pct = (phase < 2) ? 30 : ((phase < 4) ? 64 : 0);
         recv_idle_pct = (phase < 2) ? 64 : ((phase < 4) ? 30 : 0);
         jobs_queued = 0;
         while (jobs_queued < ITEMS_PER_PHASE) begin
            if (rnd(0, 99) < 15)
               push_noise();
            else
               push_approach();
            while (pending_jobs.size() > 32) @(posedge clock);
         end
         drain();
      end

      if (errors == 0 && expected_cmds.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

### sim.f
src/gtg_pkg.sv
src/gtg_front.sv
src/gtg_cordic.sv
src/gtg_back.sv
src/go_to_goal_steering_controller_top.sv
bench/go_to_goal_steering_controller_top_tb.sv
